// ----- design/fpic_pkg.sv -----
// Shared constants and types of the force PID / impedance controller.
package fpic_pkg;

    localparam int DATA_W      = 32;
    localparam int FRAC_W      = 16;
    localparam int SUM_W       = 48;
    localparam int CFG_IDX_W   = 3;
    localparam int DERIV_SCALE = 1000;

    // Error difference and its scaled form
    localparam int DIFF_W   = DATA_W + 1;
    localparam int DER_W    = DIFF_W + $clog2(DERIV_SCALE + 1);

    // Wide operands are split into an unsigned low slice and a signed high slice
    localparam int LO_W     = 24;
    localparam int SUM_HI_W = SUM_W - LO_W;
    localparam int DER_HI_W = DER_W - LO_W;

    // Products and the accumulated Q50.32 sum
    localparam int PROD_W   = 2 * DATA_W + 1;
    localparam int C_W      = SUM_HI_W + DATA_W;
    localparam int D_W      = LO_W + 1 + DATA_W;
    localparam int E_W      = DER_HI_W + DATA_W;
    localparam int ACC_W    = (((DER_W + DATA_W) > (SUM_W + DATA_W)) ?
                               (DER_W + DATA_W) : (SUM_W + DATA_W)) + 2;

    localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [SUM_W-1:0]  SUM_MAX  = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0]  SUM_MIN  = {1'b1, {(SUM_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE          = 3'd0,
        REG_TARGET_FORCE  = 3'd1,
        REG_GAIN_P        = 3'd2,
        REG_GAIN_I        = 3'd3,
        REG_GAIN_D        = 3'd4,
        REG_REST_POSITION = 3'd5,
        REG_STIFFNESS     = 3'd6,
        REG_DAMPING       = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic                     mode;
        logic signed [DATA_W-1:0] target_force;
        logic signed [DATA_W-1:0] gain_p;
        logic signed [DATA_W-1:0] gain_i;
        logic signed [DATA_W-1:0] gain_d;
        logic signed [DATA_W-1:0] rest_position;
        logic signed [DATA_W-1:0] stiffness;
        logic signed [DATA_W-1:0] damping;
    } cfg_t;

endpackage

// ----- design/force_pid_impedance_controller_top.sv -----
// Top level of the force PID / impedance controller: five-stage pipeline.
//
//   Channel  Handshake             Payload
//   -------  --------------------  ----------------------------------------------
//   cfg      cfg_valid/cfg_ready   cfg_index, cfg_data
//   in       in_valid/in_ready     active, measured_force, joint_position,
//                                  joint_speed
//   out      out_valid/out_ready   drive_force
//
// One request is taken per cycle while the output is not stalled; its result passes
// through the input register, error/state stage, multiplier stage, second multiplier
// stage, and sum and saturate into the output register. The error sum and last error
// are written, for active items in PID mode (mode 0), at the edge where an item leaves
// the input register, so the next item sees them at once and items follow back to
// back. Inactive requests are dropped at that edge and give no result.
// Reset clears the pipeline valid bits, the controller state and the config registers.
// A stalled output holds its result; each stage fills while later stages wait.
module force_pid_impedance_controller_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fpic_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fpic_pkg::DATA_W-1:0]         cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                active,
    input  logic signed [fpic_pkg::DATA_W-1:0]  measured_force,
    input  logic signed [fpic_pkg::DATA_W-1:0]  joint_position,
    input  logic signed [fpic_pkg::DATA_W-1:0]  joint_speed,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [fpic_pkg::DATA_W-1:0]  drive_force
);

    localparam int DW   = fpic_pkg::DATA_W;
    localparam int SW   = fpic_pkg::SUM_W;
    localparam int LW   = fpic_pkg::LO_W;
    localparam int AW   = fpic_pkg::ACC_W;
    localparam int SATB = fpic_pkg::FRAC_W + fpic_pkg::DATA_W - 1;

    fpic_pkg::cfg_t cfg;

    fpic_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Stage valid bits and controller state
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, out_valid_reg;
    logic signed [SW-1:0] error_sum_reg;
    logic signed [DW-1:0] last_error_reg;

    // Stage payloads
    logic                               s1_active_reg;
    logic signed [DW-1:0]               s1_force_reg, s1_pos_reg, s1_speed_reg;
    logic                               s2_mode_reg;
    logic signed [DW-1:0]               s2_err_reg, s2_speed_reg;
    logic signed [fpic_pkg::DIFF_W-1:0] s2_diff_reg, s2_dpos_reg;
    logic signed [SW-1:0]               s2_sum_reg;
    logic                               s3_mode_reg;
    logic signed [fpic_pkg::DER_W-1:0]  s3_der_reg;
    logic signed [fpic_pkg::PROD_W-1:0] s3_a_reg, s3_b_reg;
    logic signed [fpic_pkg::C_W-1:0]    s3_c_reg;
    logic signed [AW-1:0]               s4_t1_reg;
    logic signed [fpic_pkg::D_W-1:0]    s4_d_reg;
    logic signed [fpic_pkg::E_W-1:0]    s4_e_reg;
    logic signed [DW-1:0]               drive_force_reg;

    // Backpressure chain
    logic s1_ready, s2_ready, s3_ready, s4_ready, s5_ready;
    logic s1_move, state_update;

    assign s5_ready = !out_valid_reg || out_ready;
    assign s4_ready = !s4_valid_reg || s5_ready;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    assign s1_move      = s1_valid_reg && s2_ready;
    assign state_update = s1_move && s1_active_reg && !cfg.mode;

    // Error stage: saturated error, difference, saturated running sum and position offset
    logic signed [DW:0]               err_wide;
    logic signed [DW-1:0]             err_sat;
    logic signed [fpic_pkg::DIFF_W-1:0] diff;
    logic signed [SW:0]               sum_wide;
    logic signed [SW-1:0]             sum_sat;
    logic signed [fpic_pkg::DIFF_W-1:0] dpos;

    always_comb
    begin
        err_wide = (DW+1)'(cfg.target_force) - (DW+1)'(s1_force_reg);
        if (err_wide[DW] != err_wide[DW-1])
            err_sat = err_wide[DW] ? fpic_pkg::DATA_MIN : fpic_pkg::DATA_MAX;
        else
            err_sat = err_wide[DW-1:0];

        diff = fpic_pkg::DIFF_W'(err_sat) - fpic_pkg::DIFF_W'(last_error_reg);

        sum_wide = (SW+1)'(error_sum_reg) + (SW+1)'(err_sat);
        if (sum_wide[SW] != sum_wide[SW-1])
            sum_sat = sum_wide[SW] ? fpic_pkg::SUM_MIN : fpic_pkg::SUM_MAX;
        else
            sum_sat = sum_wide[SW-1:0];

        dpos = fpic_pkg::DIFF_W'(cfg.rest_position) - fpic_pkg::DIFF_W'(s1_pos_reg);
    end

    // First multiplier stage: proportional, spring, damping and integral terms, scaled error difference
    logic signed [DW:0]                 a_op, b_op;
    logic signed [DW-1:0]               a_gain, b_gain;
    logic signed [fpic_pkg::SUM_HI_W-1:0] c_op;
    logic signed [fpic_pkg::PROD_W-1:0] prod_a, prod_b;
    logic signed [fpic_pkg::C_W-1:0]    prod_c;
    logic signed [fpic_pkg::DER_W-1:0]  der;

    always_comb
    begin
        if (s2_mode_reg)
        begin
            a_op   = s2_dpos_reg;
            a_gain = cfg.stiffness;
            b_op   = (DW+1)'(s2_speed_reg);
            b_gain = cfg.damping;
            c_op   = '0;
            der    = '0;
        end
        else
        begin
            a_op   = (DW+1)'(s2_err_reg);
            a_gain = cfg.gain_p;
            b_op   = {{(DW+1-LW){1'b0}}, s2_sum_reg[LW-1:0]};
            b_gain = cfg.gain_i;
            c_op   = s2_sum_reg[SW-1:LW];
            der    = fpic_pkg::DER_W'(s2_diff_reg)
                   * $signed(fpic_pkg::DER_W'(fpic_pkg::DERIV_SCALE));
        end
        prod_a = a_op * a_gain;
        prod_b = b_op * b_gain;
        prod_c = c_op * cfg.gain_i;
    end

    // Second multiplier stage: derivative terms and first partial sum
    logic signed [LW:0]                   d_op;
    logic signed [fpic_pkg::DER_HI_W-1:0] e_op;
    logic signed [fpic_pkg::D_W-1:0]      prod_d;
    logic signed [fpic_pkg::E_W-1:0]      prod_e;
    logic signed [AW-1:0]                 t1;

    always_comb
    begin
        d_op   = {1'b0, s3_der_reg[LW-1:0]};
        e_op   = s3_der_reg[fpic_pkg::DER_W-1:LW];
        prod_d = d_op * cfg.gain_d;
        prod_e = e_op * cfg.gain_d;
        if (s3_mode_reg)
            t1 = AW'(s3_a_reg) - AW'(s3_b_reg);
        else
            t1 = AW'(s3_a_reg) + AW'(s3_b_reg) + (AW'(s3_c_reg) <<< LW);
    end

    // Output stage: final sum, floor shift to Q16.16 and saturate
    logic signed [AW-1:0]      total;
    logic [AW-1-SATB:0]        total_hi;
    logic signed [DW-1:0]      drive_next;

    always_comb
    begin
        total    = s4_t1_reg + AW'(s4_d_reg) + (AW'(s4_e_reg) <<< LW);
        total_hi = total[AW-1:SATB];
        if (total_hi == '0 || total_hi == '1)
            drive_next = total[SATB:fpic_pkg::FRAC_W];
        else
            drive_next = total[AW-1] ? fpic_pkg::DATA_MIN : fpic_pkg::DATA_MAX;
    end

    // Advance valid bits and update controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            s4_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            error_sum_reg  <= '0;
            last_error_reg <= '0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= in_valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg && s1_active_reg;
            if (s3_ready)
                s3_valid_reg <= s2_valid_reg;
            if (s4_ready)
                s4_valid_reg <= s3_valid_reg;
            if (s5_ready)
                out_valid_reg <= s4_valid_reg;
            if (state_update)
            begin
                error_sum_reg  <= sum_sat;
                last_error_reg <= err_sat;
            end
        end
    end

    // Load stage payloads as requests move down the pipeline
    always_ff @(posedge clk)
    begin
        if (in_valid && s1_ready)
        begin
            s1_active_reg <= active;
            s1_force_reg  <= measured_force;
            s1_pos_reg    <= joint_position;
            s1_speed_reg  <= joint_speed;
        end
        if (s1_move)
        begin
            s2_mode_reg  <= cfg.mode;
            s2_err_reg   <= err_sat;
            s2_diff_reg  <= diff;
            s2_sum_reg   <= sum_sat;
            s2_dpos_reg  <= dpos;
            s2_speed_reg <= s1_speed_reg;
        end
        if (s2_valid_reg && s3_ready)
        begin
            s3_mode_reg <= s2_mode_reg;
            s3_der_reg  <= der;
            s3_a_reg    <= prod_a;
            s3_b_reg    <= prod_b;
            s3_c_reg    <= prod_c;
        end
        if (s3_valid_reg && s4_ready)
        begin
            s4_t1_reg <= t1;
            s4_d_reg  <= prod_d;
            s4_e_reg  <= prod_e;
        end
        if (s4_valid_reg && s5_ready)
            drive_force_reg <= drive_next;
    end

    assign out_valid   = out_valid_reg;
    assign drive_force = drive_force_reg;

endmodule

// ----- design/fpic_cfg_regs.sv -----
// Configuration register file of the force PID / impedance controller.
module fpic_cfg_regs
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fpic_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fpic_pkg::DATA_W-1:0]     cfg_data,
    output fpic_pkg::cfg_t                  cfg
);

    fpic_pkg::cfg_t cfg_reg;

    // Take a write request in every cycle
    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    // Write the addressed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (fpic_pkg::cfg_index_t'(cfg_index))
                fpic_pkg::REG_MODE:          cfg_reg.mode          <= cfg_data[0];
                fpic_pkg::REG_TARGET_FORCE:  cfg_reg.target_force  <= cfg_data;
                fpic_pkg::REG_GAIN_P:        cfg_reg.gain_p        <= cfg_data;
                fpic_pkg::REG_GAIN_I:        cfg_reg.gain_i        <= cfg_data;
                fpic_pkg::REG_GAIN_D:        cfg_reg.gain_d        <= cfg_data;
                fpic_pkg::REG_REST_POSITION: cfg_reg.rest_position <= cfg_data;
                fpic_pkg::REG_STIFFNESS:     cfg_reg.stiffness     <= cfg_data;
                fpic_pkg::REG_DAMPING:       cfg_reg.damping       <= cfg_data;
                default:                     cfg_reg               <= cfg_reg;
            endcase
        end
    end

endmodule
